// ----- sv/ase_pkg.sv -----
// types, constants and codes shared by the array store engine
package ase_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [LEN_W-1:0]   LEN_RESET         = 5'd16;
  localparam logic [PADDR_W-1:0] ADDR_ARRAY_LENGTH = 2'd0;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_SEARCH    = 3'd1,
    OP_REVERSE   = 3'd2,
    OP_SORT_ASC  = 3'd3,
    OP_SORT_DESC = 3'd4,
    OP_READ      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        found_position;
    logic signed [DATA_W-1:0] element;
    logic                    last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_W2,
    S_OUT_RD,
    S_OUT_EMIT,
    S_RESP_OK,
    S_RESP_INVALID,
    S_RESP_NOT_FOUND,
    S_RESP_FOUND
  } state_e;

  typedef enum logic [1:0] {
    RD_I,
    RD_PAIR,
    RD_IJ
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_POS,
    WR_I_B,
    WR_I1_A,
    WR_J_A
  } wr_sel_e;

  typedef enum logic [2:0] {
    OUT_OK,
    OUT_INVALID,
    OUT_NOT_FOUND,
    OUT_FOUND,
    OUT_ELEM
  } out_kind_e;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      step_i;
    logic      step_sort;
    logic      step_rev;
    logic      out_load;
    out_kind_e out_kind;
  } ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic n_small;
    logic pos_ok;
    logic match;
    logic swap;
    logic i_last;
    logic sort_last;
    logic rev_more;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/ase_ram.sv -----
// generic ram, one write port, two registered read ports
module ase_ram #(
  parameter int unsigned WIDTH = ase_pkg::WIDTH_DEF,
  parameter int unsigned DEPTH = ase_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- sv/ase_ctrl.sv -----
// controller state machine of the array store engine
module ase_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     opcode_i,
  input  ase_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output ase_pkg::ctrl_t ctrl_o
);

  ase_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ase_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ase_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          unique case (opcode_i) inside
            ase_pkg::OP_WRITE: state_d = ase_pkg::S_WRITE;
            ase_pkg::OP_SEARCH: begin
              state_d = stat_i.n_zero ? ase_pkg::S_RESP_NOT_FOUND : ase_pkg::S_SRCH_RD;
            end
            ase_pkg::OP_REVERSE: begin
              state_d = stat_i.n_small ? ase_pkg::S_RESP_OK : ase_pkg::S_REV_RD;
            end
            ase_pkg::OP_SORT_ASC, ase_pkg::OP_SORT_DESC: begin
              state_d = stat_i.n_small ? ase_pkg::S_RESP_OK : ase_pkg::S_SORT_RD;
            end
            ase_pkg::OP_READ: begin
              state_d = stat_i.n_zero ? ase_pkg::S_IDLE : ase_pkg::S_OUT_RD;
            end
            default: state_d = ase_pkg::S_IDLE;
          endcase
        end
      end
      ase_pkg::S_WRITE: begin
        if (stat_i.pos_ok) begin
          ctrl_o.wr_en  = 1'b1;
          ctrl_o.wr_sel = ase_pkg::WR_POS;
          state_d       = ase_pkg::S_RESP_OK;
        end else begin
          state_d = ase_pkg::S_RESP_INVALID;
        end
      end
      ase_pkg::S_SRCH_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = ase_pkg::RD_I;
        state_d       = ase_pkg::S_SRCH_CMP;
      end
      ase_pkg::S_SRCH_CMP: begin
        if (stat_i.match) begin
          state_d = ase_pkg::S_RESP_FOUND;
        end else if (stat_i.i_last) begin
          state_d = ase_pkg::S_RESP_NOT_FOUND;
        end else begin
          ctrl_o.step_i = 1'b1;
          state_d       = ase_pkg::S_SRCH_RD;
        end
      end
      ase_pkg::S_REV_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = ase_pkg::RD_IJ;
        state_d       = ase_pkg::S_REV_W1;
      end
      ase_pkg::S_REV_W1: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = ase_pkg::WR_I_B;
        state_d       = ase_pkg::S_REV_W2;
      end
      ase_pkg::S_REV_W2: begin
        ctrl_o.wr_en    = 1'b1;
        ctrl_o.wr_sel   = ase_pkg::WR_J_A;
        ctrl_o.step_rev = 1'b1;
        state_d = stat_i.rev_more ? ase_pkg::S_REV_RD : ase_pkg::S_RESP_OK;
      end
      ase_pkg::S_SORT_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = ase_pkg::RD_PAIR;
        state_d       = ase_pkg::S_SORT_CMP;
      end
      ase_pkg::S_SORT_CMP: begin
        if (stat_i.swap) begin
          ctrl_o.wr_en  = 1'b1;
          ctrl_o.wr_sel = ase_pkg::WR_I_B;
          state_d       = ase_pkg::S_SORT_W2;
        end else begin
          ctrl_o.step_sort = 1'b1;
          state_d = stat_i.sort_last ? ase_pkg::S_RESP_OK : ase_pkg::S_SORT_RD;
        end
      end
      ase_pkg::S_SORT_W2: begin
        ctrl_o.wr_en     = 1'b1;
        ctrl_o.wr_sel    = ase_pkg::WR_I1_A;
        ctrl_o.step_sort = 1'b1;
        state_d = stat_i.sort_last ? ase_pkg::S_RESP_OK : ase_pkg::S_SORT_RD;
      end
      ase_pkg::S_OUT_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = ase_pkg::RD_I;
        state_d       = ase_pkg::S_OUT_EMIT;
      end
      ase_pkg::S_OUT_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = ase_pkg::OUT_ELEM;
          if (stat_i.i_last) begin
            state_d = ase_pkg::S_IDLE;
          end else begin
            ctrl_o.step_i = 1'b1;
            state_d       = ase_pkg::S_OUT_RD;
          end
        end
      end
      ase_pkg::S_RESP_OK: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = ase_pkg::OUT_OK;
          state_d         = ase_pkg::S_IDLE;
        end
      end
      ase_pkg::S_RESP_INVALID: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = ase_pkg::OUT_INVALID;
          state_d         = ase_pkg::S_IDLE;
        end
      end
      ase_pkg::S_RESP_NOT_FOUND: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = ase_pkg::OUT_NOT_FOUND;
          state_d         = ase_pkg::S_IDLE;
        end
      end
      ase_pkg::S_RESP_FOUND: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = ase_pkg::OUT_FOUND;
          state_d         = ase_pkg::S_IDLE;
        end
      end
      default: state_d = ase_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/ase_datapath.sv -----
// datapath: element store, index counters, compare and result register
module ase_datapath #(
  parameter int unsigned DEPTH = ase_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ase_pkg::WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ase_pkg::req_t             req_i,
  input  logic [ase_pkg::LEN_W-1:0] array_length_i,
  input  ase_pkg::ctrl_t            ctrl_i,
  input  logic                      out_ready_i,
  output ase_pkg::stat_t            stat_o,
  output logic                      out_valid_o,
  output ase_pkg::res_t             out_data_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > ase_pkg::LEN_W) ? CNT_W : ase_pkg::LEN_W;

  logic [CMP_W-1:0]  len_ext, depth_ext, n_full, pos_ext;
  logic [CNT_W-1:0]  n, i_inc;
  logic [ADDR_W-1:0] i_q, j_q, end_q, i1;

  logic [ase_pkg::POS_W-1:0] pos_q;
  logic signed [WIDTH-1:0]   key_q;
  logic                      desc_q;

  logic [DEPTH-1:0]        valid_q;
  logic                    valid_a_q, valid_b_q;
  logic [ADDR_W-1:0]       raddr_a, raddr_b, waddr;
  logic [WIDTH-1:0]        wdata, rdata_a, rdata_b;
  logic signed [WIDTH-1:0] a_w, b_w;

  ase_pkg::res_t res_q, res_d;
  logic          out_valid_q;

  // used length, capped at the store depth
  assign len_ext   = CMP_W'(array_length_i);
  assign depth_ext = CMP_W'(DEPTH);
  assign n_full    = (len_ext > depth_ext) ? depth_ext : len_ext;
  assign n         = CNT_W'(n_full);
  assign pos_ext   = CMP_W'(pos_q);
  assign i_inc     = CNT_W'(i_q) + CNT_W'(1);
  assign i1        = i_q + ADDR_W'(1);

  // never-written entries read as zero
  assign a_w = valid_a_q ? $signed(rdata_a) : '0;
  assign b_w = valid_b_q ? $signed(rdata_b) : '0;

  always_comb begin
    raddr_a = i_q;
    raddr_b = i_q;
    case (ctrl_i.rd_sel)
      ase_pkg::RD_PAIR: raddr_b = i1;
      ase_pkg::RD_IJ:   raddr_b = j_q;
      default:          raddr_b = i_q;
    endcase
  end

  always_comb begin
    waddr = i_q;
    wdata = b_w;
    case (ctrl_i.wr_sel)
      ase_pkg::WR_POS: begin
        waddr = ADDR_W'(pos_ext - CMP_W'(1));
        wdata = key_q;
      end
      ase_pkg::WR_I_B: begin
        waddr = i_q;
        wdata = b_w;
      end
      ase_pkg::WR_I1_A: begin
        waddr = i1;
        wdata = a_w;
      end
      default: begin
        waddr = j_q;
        wdata = a_w;
      end
    endcase
  end

  ase_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ctrl_i.wr_en),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_i     (ctrl_i.rd_en),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        valid_a_q <= valid_q[raddr_a];
        valid_b_q <= valid_q[raddr_b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      pos_q  <= req_i.position;
      key_q  <= WIDTH'(req_i.value);
      desc_q <= (req_i.opcode == ase_pkg::OP_SORT_DESC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      j_q   <= '0;
      end_q <= '0;
    end else if (ctrl_i.latch) begin
      i_q   <= '0;
      j_q   <= ADDR_W'(n - CNT_W'(1));
      end_q <= ADDR_W'(n - CNT_W'(1));
    end else if (ctrl_i.step_i) begin
      i_q <= i1;
    end else if (ctrl_i.step_rev) begin
      i_q <= i1;
      j_q <= j_q - ADDR_W'(1);
    end else if (ctrl_i.step_sort) begin
      if (i1 == end_q) begin
        i_q   <= '0;
        end_q <= end_q - ADDR_W'(1);
      end else begin
        i_q <= i1;
      end
    end
  end

  always_comb begin
    stat_o.n_zero    = (n == '0);
    stat_o.n_small   = (n < CNT_W'(2));
    stat_o.pos_ok    = (pos_ext != '0) && (pos_ext <= CMP_W'(n));
    stat_o.match     = (a_w == key_q);
    stat_o.swap      = desc_q ? (a_w < b_w) : (a_w > b_w);
    stat_o.i_last    = (i_inc == n);
    stat_o.sort_last = (i1 == end_q) && (end_q == ADDR_W'(1));
    stat_o.rev_more  = (i1 < (j_q - ADDR_W'(1)));
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    res_d                = '0;
    res_d.status         = ase_pkg::ST_OK;
    res_d.last           = 1'b1;
    case (ctrl_i.out_kind)
      ase_pkg::OUT_INVALID:   res_d.status = ase_pkg::ST_INVALID;
      ase_pkg::OUT_NOT_FOUND: res_d.status = ase_pkg::ST_NOT_FOUND;
      ase_pkg::OUT_FOUND:     res_d.found_position = ase_pkg::POS_W'(i_inc);
      ase_pkg::OUT_ELEM: begin
        res_d.element = ase_pkg::DATA_W'(a_w);
        res_d.last    = (i_inc == n);
      end
      default: res_d.status = ase_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

// ----- sv/array_store_engine.sv -----
// top level of the array store engine
// Holds DEPTH signed words, of which the first array_length (capped at DEPTH) are in use;
// the store reads as all zero after reset. One request is worked at a time and the next
// is taken once the previous one has put its last result, if any, in the output register.
// All store traffic goes through one RAM with a single write port and two read ports:
// search reads and compares one element at a time, reverse reads a pair and writes
// both back, and sorts compare neighbours and swap them over n(n-1)/2 compares. Each
// request yields one result, read-out one per element with last on the final one; unused
// opcodes and read-out of an empty array yield none.
module array_store_engine #(
  parameter int unsigned DEPTH = ase_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ase_pkg::WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ase_pkg::req_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ase_pkg::res_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ase_pkg::PADDR_W-1:0] paddr,
  input  logic [ase_pkg::PDATA_W-1:0] pwdata,
  output logic [ase_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [ase_pkg::LEN_W-1:0] array_length_q;
  ase_pkg::ctrl_t            ctrl;
  ase_pkg::stat_t            stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= ase_pkg::LEN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      array_length_q <= pwdata[ase_pkg::LEN_W-1:0];
    end
  end

  assign prdata = (paddr == ase_pkg::ADDR_ARRAY_LENGTH) ?
                  ase_pkg::PDATA_W'(array_length_q) : '0;

  ase_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (in_data_i.opcode),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .ctrl_o    (ctrl)
  );

  ase_datapath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (in_data_i),
    .array_length_i(array_length_q),
    .ctrl_i        (ctrl),
    .out_ready_i   (out_ready_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- test/array_store_engine_tb.sv -----
// self-checking testbench for the array store engine: directed and random requests
module array_store_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int unsigned STORE_DEPTH = ase_pkg::DEPTH_DEF;
  localparam int SETTLE_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 168;
  localparam int REPORT_MAX = 10;

  class store_scoreboard;
    logic signed [ase_pkg::DATA_W-1:0] words [STORE_DEPTH];
    logic [ase_pkg::LEN_W-1:0] length_reg;
    ase_pkg::res_t due[$];
    int fail_count;
    int seen;

    function new();
      foreach (words[i]) words[i] = '0;
      length_reg = ase_pkg::LEN_RESET;
      fail_count = 0;
      seen = 0;
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%s", msg);
    endfunction

    function int unsigned used();
      return (length_reg > STORE_DEPTH) ? STORE_DEPTH : length_reg;
    endfunction

    function void set_length(logic [ase_pkg::LEN_W-1:0] len);
      length_reg = len;
    endfunction

    function void bubble(int unsigned n, bit descending);
      logic signed [ase_pkg::DATA_W-1:0] a, b;
      for (int unsigned p = 1; p < n; p++) begin
        for (int unsigned i = 0; i + p < n; i++) begin
          a = words[i];
          b = words[i+1];
          if (descending ? (a < b) : (a > b)) begin
            words[i] = b;
            words[i+1] = a;
          end
        end
      end
    endfunction

    // work out the results of one accepted request and update the store copy
    function void log_request(ase_pkg::req_t r);
      int unsigned n;
      logic signed [ase_pkg::DATA_W-1:0] t;
      ase_pkg::res_t e;
      bit hit;
      n = used();
      e = '0;
      e.last = 1'b1;
      hit = 1'b0;
      case (r.opcode) inside
        ase_pkg::OP_WRITE: begin
          if (r.position < 1 || r.position > n) begin
            e.status = ase_pkg::ST_INVALID;
          end else begin
            words[r.position-1] = r.value;
            e.status = ase_pkg::ST_OK;
          end
          due.push_back(e);
        end
        ase_pkg::OP_SEARCH: begin
          e.status = ase_pkg::ST_NOT_FOUND;
          for (int unsigned i = 0; i < n && !hit; i++) begin
            if (words[i] == r.value) begin
              hit = 1'b1;
              e.status = ase_pkg::ST_OK;
              e.found_position = ase_pkg::POS_W'(i + 1);
            end
          end
          due.push_back(e);
        end
        ase_pkg::OP_REVERSE: begin
          for (int unsigned i = 0; i < n / 2; i++) begin
            t = words[i];
            words[i] = words[n-1-i];
            words[n-1-i] = t;
          end
          e.status = ase_pkg::ST_OK;
          due.push_back(e);
        end
        ase_pkg::OP_SORT_ASC, ase_pkg::OP_SORT_DESC: begin
          bubble(n, r.opcode == ase_pkg::OP_SORT_DESC);
          e.status = ase_pkg::ST_OK;
          due.push_back(e);
        end
        ase_pkg::OP_READ: begin
          for (int unsigned i = 0; i < n; i++) begin
            e.status = ase_pkg::ST_OK;
            e.found_position = '0;
            e.element = words[i];
            e.last = (i + 1 == n);
            due.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(ase_pkg::res_t got);
      ase_pkg::res_t e;
      seen++;
      if (due.size() == 0) begin
        report($sformatf("result %0d unexpected: st=%0d pos=%0d elem=%0d last=%0d",
                         seen, got.status, got.found_position, got.element, got.last));
        return;
      end
      e = due.pop_front();
      if (got.status !== e.status || got.found_position !== e.found_position ||
          got.element !== e.element || got.last !== e.last) begin
        report($sformatf({"result %0d mismatch: expected st=%0d pos=%0d elem=%0d last=%0d,",
                          " got st=%0d pos=%0d elem=%0d last=%0d"}, seen,
                         e.status, e.found_position, e.element, e.last,
                         got.status, got.found_position, got.element, got.last));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ase_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ase_pkg::res_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ase_pkg::PADDR_W-1:0] paddr = '0;
  logic [ase_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ase_pkg::PDATA_W-1:0] prdata;
  logic pready;

  store_scoreboard sb = new();

  int quiet_cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int burst_left = 3;
  int burst_count = 0;
  bit valid_up = 1'b0;

  array_store_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check, then stall according to a mode that is repicked at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    rx_tick++;
    if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= (rx_tick % 3 == 0);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic ase_pkg::req_t build_request(logic [2:0] op,
                                                  logic [ase_pkg::POS_W-1:0] pos,
                                                  logic signed [ase_pkg::DATA_W-1:0] val);
    ase_pkg::req_t r;
    r.opcode = op;
    r.position = pos;
    r.value = val;
    return r;
  endfunction

  function automatic logic signed [ase_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      4, 5: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic ase_pkg::req_t random_request();
    ase_pkg::req_t r;
    int unsigned n;
    int unsigned roll;
    n = sb.used();
    roll = $urandom_range(0, 99);
    r.value = pick_value();
    if (n > 0 && $urandom_range(0, 3) != 0)
      r.position = ase_pkg::POS_W'($urandom_range(1, n));
    else
      r.position = ase_pkg::POS_W'($urandom_range(0, 31));
    if (roll < 38) begin
      r.opcode = ase_pkg::OP_WRITE;
    end else if (roll < 58) begin
      r.opcode = ase_pkg::OP_SEARCH;
      if (n > 0 && $urandom_range(0, 1) == 1) r.value = sb.words[$urandom_range(0, n - 1)];
    end else if (roll < 66) begin
      r.opcode = ase_pkg::OP_REVERSE;
    end else if (roll < 73) begin
      r.opcode = ase_pkg::OP_SORT_ASC;
    end else if (roll < 80) begin
      r.opcode = ase_pkg::OP_SORT_DESC;
    end else if (roll < 94) begin
      r.opcode = ase_pkg::OP_READ;
    end else begin
      r.opcode = ($urandom_range(0, 1) == 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    end
    return r;
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  // called at a rising edge; returns after the request is taken and any gap
  task automatic send_paced(ase_pkg::req_t r);
    int gap;
    bit hold;
    in_data_i <= r;
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.log_request(r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_count++;
      burst_left = $urandom_range(1, 8);
      hold = (burst_count % 9 == 4);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (hold && gap == 0) gap = 1;
      if (hold || gap > 0) begin
        lower_valid();
        if (hold) wait_drained();
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_length(logic [ase_pkg::LEN_W-1:0] len);
    logic [ase_pkg::PDATA_W-1:0] data;
    data = ($urandom & ~ase_pkg::PDATA_W'(32'h1f)) | ase_pkg::PDATA_W'(len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ase_pkg::ADDR_ARRAY_LENGTH;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_length(len);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== ase_pkg::PDATA_W'(len))
      sb.report($sformatf("length read back %0d, expected %0d", prdata, len));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic change_length(logic [ase_pkg::LEN_W-1:0] len);
    lower_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_length(len);
  endtask

  task automatic drive_random(int count);
    ase_pkg::req_t r;
    while (count > 0) begin
      r = random_request();
      send_paced(r);
      if (r.opcode != OP_UNUSED_LO && r.opcode != OP_UNUSED_HI) count--;
    end
  endtask

  initial begin
    int unsigned phase_len [8] = '{1, 2, 31, 16, 5, 0, 20, 9};
    int per_phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // store should read back cleared
    send_paced(build_request(ase_pkg::OP_READ, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd0, 32'sd5));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd1, 32'sh7fffffff));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd16, 32'sh80000000));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd17, 32'sd9));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd31, -32'sd1));
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd8, -32'sd1));
    send_paced(build_request(ase_pkg::OP_SEARCH, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_SEARCH, 5'd31, 32'sh80000000));
    send_paced(build_request(ase_pkg::OP_SEARCH, 5'd3, 32'sd12345));
    send_paced(build_request(ase_pkg::OP_READ, 5'd31, -32'sd1));
    send_paced(build_request(ase_pkg::OP_SORT_ASC, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_READ, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_SORT_DESC, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_REVERSE, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_READ, 5'd0, 32'sd0));
    send_paced(build_request(OP_UNUSED_LO, 5'd31, -32'sd1));
    send_paced(build_request(OP_UNUSED_HI, 5'd1, 32'sd1));
    send_paced(build_request(ase_pkg::OP_SEARCH, 5'd0, 32'sh7fffffff));

    // empty array
    change_length(5'd0);
    send_paced(build_request(ase_pkg::OP_WRITE, 5'd1, 32'sd3));
    send_paced(build_request(ase_pkg::OP_SEARCH, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_REVERSE, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_SORT_ASC, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_SORT_DESC, 5'd0, 32'sd0));
    send_paced(build_request(ase_pkg::OP_READ, 5'd0, 32'sd0));

    per_phase = (RANDOM_ITEMS + 7) / 8;
    foreach (phase_len[p]) begin
      change_length(ase_pkg::LEN_W'(phase_len[p]));
      drive_random(per_phase);
    end

    lower_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.due.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.due.size()));
    if (sb.fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
